// ===== hw/rtl/dllm_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and operation codes for the doubly linked list manager.
package dllm_pkg;

   localparam int MODE_W = 2;

   localparam logic [MODE_W-1:0] MODE_PUSH   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_POP    = 2'd1;
   localparam logic [MODE_W-1:0] MODE_UNLINK = 2'd2;

   // Commands from the sequencer to the datapath
   typedef struct packed {
      logic clear;   // write null into both link memories at the sweep address
      logic start;   // latch the request word and read the link memories
      logic link;    // rewrite neighbor links (the node's own links for push)
      logic fin;     // rewrite the node's own links (the old head's prev link for push)
      logic commit;  // update head, tail, count and load the response
   } cmd_type;

   // Status from the datapath to the sequencer
   typedef struct packed {
      logic clear_last;  // sweep address at the last entry
      logic out_free;    // response register can take a word this cycle
   } status_type;

endpackage

// ===== hw/rtl/dllm_if.sv =====
`timescale 1ns / 1ps
// Request and response channel interfaces of the doubly linked list manager.
interface dllm_req_if #(
   parameter int NODES = 64
);
   localparam int IDX_W = $clog2(NODES);

   logic                        valid;
   logic                        ready;
   logic [dllm_pkg::MODE_W-1:0] mode;
   logic [IDX_W-1:0]            node_index;

   modport source (output valid, output mode, output node_index, input ready);
   modport sink   (input valid, input mode, input node_index, output ready);
endinterface

interface dllm_rsp_if #(
   parameter int NODES = 64
);
   localparam int IDX_W = $clog2(NODES);
   localparam int CNT_W = $clog2(NODES + 1);

   logic             valid;
   logic             ready;
   logic [IDX_W-1:0] result_node;
   logic             result_valid;
   logic [CNT_W-1:0] list_count;
   logic             list_empty;
   logic [IDX_W-1:0] front_node;
   logic             front_valid;

   modport source (output valid, output result_node, output result_valid,
                   output list_count, output list_empty, output front_node,
                   output front_valid, input ready);
   modport sink   (input valid, input result_node, input result_valid,
                   input list_count, input list_empty, input front_node,
                   input front_valid, output ready);
endinterface

// ===== hw/rtl/dllm_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencer state machine of the doubly linked list manager.
module dllm_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  dllm_pkg::status_type status,
   output dllm_pkg::cmd_type    cmd
);

   typedef enum logic [3:0] {
      ST_CLEAR = 4'b0001,
      ST_IDLE  = 4'b0010,
      ST_LINK  = 4'b0100,
      ST_FIN   = 4'b1000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (status.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) state_in = ST_LINK;
         end
         ST_LINK: begin
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (status.out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready  = (state_ff == ST_IDLE);
   assign cmd.clear  = (state_ff == ST_CLEAR);
   assign cmd.start  = (state_ff == ST_IDLE) && req_valid;
   assign cmd.link   = (state_ff == ST_LINK);
   assign cmd.fin    = (state_ff == ST_FIN);
   assign cmd.commit = (state_ff == ST_FIN) && status.out_free;

`ifndef ASSERT_OFF
   a_reset_clears: assert property (@(posedge clock)
      $past(reset) |-> state_ff == ST_CLEAR)
      else $error("sequencer did not restart the clearing sweep after reset");

   a_commit_after_link: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> ($past(state_ff) == ST_LINK) || ($past(state_ff) == ST_FIN))
      else $error("commit without a preceding link step");

   a_state_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("sequencer state is not one-hot");
`endif

endmodule

// ===== hw/rtl/dllm_datapath.sv =====
`timescale 1ns / 1ps
// Link memories, list registers and response register of the list manager.
module dllm_datapath #(
   parameter int NODES = 64,
   parameter int IDX_W = $clog2(NODES),
   parameter int CNT_W = $clog2(NODES + 1)
) (
   input  logic                        clock,
   input  logic                        reset,
   input  dllm_pkg::cmd_type           cmd,
   output dllm_pkg::status_type        status,
   input  logic [dllm_pkg::MODE_W-1:0] req_mode,
   input  logic [IDX_W-1:0]            req_node_index,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [IDX_W-1:0]            rsp_result_node,
   output logic                        rsp_result_valid,
   output logic [CNT_W-1:0]            rsp_list_count,
   output logic                        rsp_list_empty,
   output logic [IDX_W-1:0]            rsp_front_node,
   output logic                        rsp_front_valid
);

   localparam int LINK_W = IDX_W + 1;
   localparam logic [LINK_W-1:0] NIL = LINK_W'(NODES);

   function automatic logic is_node(input logic [LINK_W-1:0] v);
      return v < NIL;
   endfunction

   // link memories, one write and one read port each
   logic [LINK_W-1:0] prev_link_mem [NODES];
   logic [LINK_W-1:0] next_link_mem [NODES];

   logic [IDX_W-1:0]            clr_addr_ff, clr_addr_in;
   logic [LINK_W-1:0]           head_ff, head_in;
   logic [LINK_W-1:0]           tail_ff, tail_in;
   logic [CNT_W-1:0]            count_ff, count_in;
   logic [dllm_pkg::MODE_W-1:0] op_ff;
   logic [IDX_W-1:0]            node_ff;
   logic                        act_ff, act_in;
   logic [LINK_W-1:0]           rd_prev_ff, rd_next_ff;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]            rsp_result_node_ff;
   logic                        rsp_result_valid_ff;
   logic [CNT_W-1:0]            rsp_list_count_ff;
   logic                        rsp_list_empty_ff;
   logic [IDX_W-1:0]            rsp_front_node_ff;
   logic                        rsp_front_valid_ff;

   logic [IDX_W-1:0]  node_in;
   logic [LINK_W-1:0] node_link;
   logic              is_head, is_tail;
   logic              prev_we, next_we;
   logic [IDX_W-1:0]  prev_wa, next_wa;
   logic [LINK_W-1:0] prev_wd, next_wd;

   // request decode at accept
   always_comb begin
      node_in = (req_mode == dllm_pkg::MODE_POP) ? head_ff[IDX_W-1:0] : req_node_index;
      case (req_mode)
         dllm_pkg::MODE_PUSH, dllm_pkg::MODE_UNLINK: begin
            act_in = {1'b0, req_node_index} < NIL;
         end
         dllm_pkg::MODE_POP: begin
            act_in = (count_ff != '0) && is_node(head_ff);
         end
         default: begin
            act_in = 1'b0;
         end
      endcase
   end

   assign node_link = {1'b0, node_ff};
   assign is_head   = (node_link == head_ff);
   assign is_tail   = (node_link == tail_ff);

   // memory write ports
   always_comb begin
      prev_we = 1'b0;
      prev_wa = node_ff;
      prev_wd = NIL;
      next_we = 1'b0;
      next_wa = node_ff;
      next_wd = NIL;
      if (cmd.clear) begin
         prev_we = 1'b1;
         prev_wa = clr_addr_ff;
         next_we = 1'b1;
         next_wa = clr_addr_ff;
      end else if (cmd.link && act_ff) begin
         case (op_ff)
            dllm_pkg::MODE_PUSH: begin
               prev_we = 1'b1;
               next_we = 1'b1;
               next_wd = (count_ff == '0) ? NIL : head_ff;
            end
            dllm_pkg::MODE_POP: begin
               prev_we = is_node(rd_next_ff);
               prev_wa = rd_next_ff[IDX_W-1:0];
            end
            dllm_pkg::MODE_UNLINK: begin
               if (is_head && is_tail) begin
                  prev_we = 1'b0;
               end else if (is_head) begin
                  prev_we = is_node(rd_next_ff);
                  prev_wa = rd_next_ff[IDX_W-1:0];
               end else if (is_tail) begin
                  next_we = is_node(rd_prev_ff);
                  next_wa = rd_prev_ff[IDX_W-1:0];
               end else begin
                  next_we = is_node(rd_prev_ff);
                  next_wa = rd_prev_ff[IDX_W-1:0];
                  next_wd = rd_next_ff;
                  prev_we = is_node(rd_next_ff);
                  prev_wa = rd_next_ff[IDX_W-1:0];
                  prev_wd = rd_prev_ff;
               end
            end
            default: begin
               prev_we = 1'b0;
            end
         endcase
      end else if (cmd.fin && act_ff) begin
         case (op_ff)
            dllm_pkg::MODE_PUSH: begin
               prev_we = (count_ff != '0) && is_node(head_ff);
               prev_wa = head_ff[IDX_W-1:0];
               prev_wd = node_link;
            end
            dllm_pkg::MODE_POP, dllm_pkg::MODE_UNLINK: begin
               prev_we = 1'b1;
               next_we = 1'b1;
            end
            default: begin
               prev_we = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (prev_we) prev_link_mem[prev_wa] <= prev_wd;
      if (cmd.start) rd_prev_ff <= prev_link_mem[node_in];
   end

   always_ff @(posedge clock) begin
      if (next_we) next_link_mem[next_wa] <= next_wd;
      if (cmd.start) rd_next_ff <= next_link_mem[node_in];
   end

   // list registers after the operation
   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (act_ff) begin
         case (op_ff)
            dllm_pkg::MODE_PUSH: begin
               head_in = node_link;
               if (count_ff == '0) tail_in = node_link;
               if (count_ff < CNT_W'(NODES)) count_in = count_ff + CNT_W'(1);
            end
            dllm_pkg::MODE_POP: begin
               head_in = rd_next_ff;
               if (!is_node(rd_next_ff)) tail_in = NIL;
               if (count_ff != '0) count_in = count_ff - CNT_W'(1);
            end
            dllm_pkg::MODE_UNLINK: begin
               if (is_head && is_tail) begin
                  head_in = NIL;
                  tail_in = NIL;
               end else if (is_head) begin
                  head_in = rd_next_ff;
               end else if (is_tail) begin
                  tail_in = rd_prev_ff;
               end
               if (count_ff != '0) count_in = count_ff - CNT_W'(1);
            end
            default: begin
               head_in = head_ff;
            end
         endcase
      end
   end

   assign clr_addr_in  = cmd.clear ? clr_addr_ff + IDX_W'(1) : clr_addr_ff;
   assign rsp_valid_in = cmd.commit ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff  <= '0;
         head_ff      <= NIL;
         tail_ff      <= NIL;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clr_addr_ff  <= clr_addr_in;
         rsp_valid_ff <= rsp_valid_in;
         if (cmd.commit) begin
            head_ff  <= head_in;
            tail_ff  <= tail_in;
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         op_ff   <= req_mode;
         node_ff <= node_in;
         act_ff  <= act_in;
      end
      if (cmd.commit) begin
         rsp_result_node_ff  <= act_ff ? node_ff : '0;
         rsp_result_valid_ff <= act_ff;
         rsp_list_count_ff   <= count_in;
         rsp_list_empty_ff   <= (count_in == '0);
         rsp_front_node_ff   <= is_node(head_in) ? head_in[IDX_W-1:0] : '0;
         rsp_front_valid_ff  <= is_node(head_in);
      end
   end

   assign status.clear_last = (clr_addr_ff == IDX_W'(NODES - 1));
   assign status.out_free   = !rsp_valid_ff || rsp_ready;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_node  = rsp_result_node_ff;
   assign rsp_result_valid = rsp_result_valid_ff;
   assign rsp_list_count   = rsp_list_count_ff;
   assign rsp_list_empty   = rsp_list_empty_ff;
   assign rsp_front_node   = rsp_front_node_ff;
   assign rsp_front_valid  = rsp_front_valid_ff;

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(NODES))
      else $error("node count beyond pool size");

   a_read_no_write: assert property (@(posedge clock) disable iff (reset)
      cmd.start |-> !prev_we && !next_we)
      else $error("link memory written in the read cycle");

   a_empty_matches_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_list_empty_ff == (rsp_list_count_ff == '0))
      else $error("empty flag disagrees with count in response word");
`endif

endmodule

// ===== hw/rtl/doubly_linked_list_manager.sv =====
`timescale 1ns / 1ps
// Top level of the doubly linked list manager over a pool of NODES node indices.
//
// Usage:
//   req_chan carries one request word: mode (push front, pop front, unlink
//   node_index) and node_index. rsp_chan returns exactly one response word
//   per request: the node concerned, its valid flag, and the list count,
//   empty flag and front node after the operation.
//   Sequence: a request runs through accept with link read, neighbor link
//   writes and own link writes with list update (for push, the own links
//   are written first and the old head's prev link last). The response
//   word is registered at the end of the last step. One request is in
//   flight at a time: a new one is accepted only after that step.
//   Reset: after reset the block sweeps every entry of both link memories
//   to null, one entry per cycle; req_chan.ready stays low meanwhile.
//   Stall: a finished response waits in the output register; a new request
//   is still accepted, and its final step holds until rsp_chan takes the
//   previous word.
module doubly_linked_list_manager #(
   parameter int NODES = 64
) (
   input logic        clock,
   input logic        reset,
   dllm_req_if.sink   req_chan,
   dllm_rsp_if.source rsp_chan
);

   localparam int IDX_W = $clog2(NODES);
   localparam int CNT_W = $clog2(NODES + 1);

   dllm_pkg::cmd_type    cmd;
   dllm_pkg::status_type status;

   // sequencer: owns request ready and step order
   dllm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath: link memories, head, tail, count and response register
   dllm_datapath #(
      .NODES (NODES),
      .IDX_W (IDX_W),
      .CNT_W (CNT_W)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_mode         (req_chan.mode),
      .req_node_index   (req_chan.node_index),
      .rsp_valid        (rsp_chan.valid),
      .rsp_ready        (rsp_chan.ready),
      .rsp_result_node  (rsp_chan.result_node),
      .rsp_result_valid (rsp_chan.result_valid),
      .rsp_list_count   (rsp_chan.list_count),
      .rsp_list_empty   (rsp_chan.list_empty),
      .rsp_front_node   (rsp_chan.front_node),
      .rsp_front_valid  (rsp_chan.front_valid)
   );

endmodule
